@@ hw/rtl/bfpu_pkg.sv @@
`timescale 1ns / 1ps

package bfpu_pkg;

    localparam int BFPU_STORE_BYTES = 32;
    localparam int BFPU_MAX_BYTES   = 32;
    localparam int BFPU_VAL_W       = 64;
    localparam int BFPU_POS_W       = 8;
    localparam int BFPU_CNT_W       = 7;
    localparam int BFPU_ADDR_W      = 5;

    typedef enum logic [1:0] {
        OP_PUT      = 2'd0,
        OP_TAKE     = 2'd1,
        OP_START_WR = 2'd2,
        OP_START_RD = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } st_t;

    typedef struct packed {
        logic [3:0] chunk;
        logic [7:0] new_byte;
        logic [7:0] rd_bits;
    } byte_res_t;

endpackage

@@ hw/rtl/bit_field_packer_unpacker_unit.sv @@
`timescale 1ns / 1ps

// Channel | Direction | Handshake            | Payload
// input   | in        | start, busy          | op, field_bits, field_value, limit_bits
// result  | out       | done (one-cycle)     | taken_value, overrun, read_bits_left,
//         |           |                      | write_bits_left
//
// Start ops, refused fields and zero-length fields: done in the cycle after acceptance.
// Put or take: works through one store byte at a time (nine at most for 64 bits), done
// in the cycle after the last byte; the shared byte merge/extract unit sets each chunk.
// Reset clears the store, positions and limits at once; no sweep follows.
// busy is high while bytes are in flight; a new item may start in the done cycle.
// The receiver cannot stall: each result stands for exactly one cycle.
module bit_field_packer_unpacker_unit #(
    parameter int STORE_BYTES = bfpu_pkg::BFPU_STORE_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      op,
    input  logic [bfpu_pkg::BFPU_CNT_W-1:0] field_bits,
    input  logic [bfpu_pkg::BFPU_VAL_W-1:0] field_value,
    input  logic [bfpu_pkg::BFPU_POS_W-1:0] limit_bits,
    output logic                            done,
    output logic [bfpu_pkg::BFPU_VAL_W-1:0] taken_value,
    output logic                            overrun,
    output logic [bfpu_pkg::BFPU_POS_W-1:0] read_bits_left,
    output logic [bfpu_pkg::BFPU_POS_W-1:0] write_bits_left
);
    import bfpu_pkg::*;

    localparam int SR_W = 2 * BFPU_VAL_W;

    st_t                   state_reg, state_next;
    logic                  is_put_reg, is_put_next;
    logic [BFPU_CNT_W-1:0] remain_reg, remain_next;
    logic [SR_W-1:0]       sr_reg, sr_next;
    logic [BFPU_VAL_W-1:0] acc_reg, acc_next;
    logic [BFPU_POS_W-1:0] wpos_reg, wpos_next;
    logic [BFPU_POS_W-1:0] wlim_reg, wlim_next;
    logic [BFPU_POS_W-1:0] rpos_reg, rpos_next;
    logic [BFPU_POS_W-1:0] rlim_reg, rlim_next;
    logic                  done_reg, done_next;
    logic                  over_reg, over_next;

    logic                  accept;
    logic                  last_byte;
    logic                  store_we;
    logic                  wr_over;
    logic                  rd_over;
    logic [BFPU_CNT_W-1:0] align_sh;
    logic [BFPU_POS_W-1:0] cur_pos;
    logic [7:0]            old_byte;
    byte_res_t             bres;
    op_t                   op_in;

    assign op_in    = op_t'(op);
    assign accept   = start && !busy;
    assign cur_pos  = is_put_reg ? wpos_reg : rpos_reg;
    assign wr_over  = ({1'b0, wpos_reg} + {2'b00, field_bits}) > {1'b0, wlim_reg};
    assign rd_over  = ({1'b0, rpos_reg} + {2'b00, field_bits}) > {1'b0, rlim_reg};
    assign align_sh = BFPU_CNT_W'(0) - field_bits;
    assign last_byte = (remain_reg == {3'd0, bres.chunk});

    bfpu_store #(
        .STORE_BYTES(STORE_BYTES)
    ) u_store (
        .clk  (clk),
        .rst_n(rst_n),
        .we   (store_we),
        .addr (cur_pos[BFPU_POS_W-1:3]),
        .wdata(bres.new_byte),
        .rdata(old_byte)
    );

    bfpu_byte_unit u_byte (
        .is_put  (is_put_reg),
        .bit_off (cur_pos[2:0]),
        .remain  (remain_reg),
        .wr_bits (sr_reg[SR_W-1 -: 8]),
        .old_byte(old_byte),
        .res     (bres)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && field_bits != '0 &&
                    ((op_in == OP_PUT && !wr_over) || (op_in == OP_TAKE && !rd_over)))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_byte)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy     = 1'b0;
        store_we = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_RUN:
            begin
                busy     = 1'b1;
                store_we = is_put_reg;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        is_put_next = is_put_reg;
        remain_next = remain_reg;
        sr_next     = sr_reg;
        acc_next    = acc_reg;
        wpos_next   = wpos_reg;
        wlim_next   = wlim_reg;
        rpos_next   = rpos_reg;
        rlim_next   = rlim_reg;
        done_next   = 1'b0;
        over_next   = over_reg;

        if (accept)
        begin
            is_put_next = (op_in == OP_PUT);
            remain_next = field_bits;
            sr_next     = {{BFPU_VAL_W{1'b0}}, field_value} << align_sh;
            acc_next    = '0;
            over_next   = 1'b0;
            done_next   = (state_next == ST_IDLE);
            case (op_in)
                OP_PUT:      over_next = wr_over;
                OP_TAKE:     over_next = rd_over;
                OP_START_WR:
                begin
                    wlim_next = limit_bits;
                    wpos_next = '0;
                end
                default:
                begin
                    rlim_next = limit_bits;
                    rpos_next = '0;
                end
            endcase
        end
        else if (state_reg == ST_RUN)
        begin
            remain_next = remain_reg - {3'd0, bres.chunk};
            sr_next     = sr_reg << bres.chunk;
            done_next   = last_byte;
            if (is_put_reg)
            begin
                wpos_next = wpos_reg + {4'd0, bres.chunk};
            end
            else
            begin
                rpos_next = rpos_reg + {4'd0, bres.chunk};
                acc_next  = (acc_reg << bres.chunk) | {{(BFPU_VAL_W-8){1'b0}}, bres.rd_bits};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wpos_reg   <= '0;
            wlim_reg   <= '0;
            rpos_reg   <= '0;
            rlim_reg   <= '0;
            done_reg   <= 1'b0;
            over_reg   <= 1'b0;
            is_put_reg <= 1'b0;
            remain_reg <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wpos_reg   <= wpos_next;
            wlim_reg   <= wlim_next;
            rpos_reg   <= rpos_next;
            rlim_reg   <= rlim_next;
            done_reg   <= done_next;
            over_reg   <= over_next;
            is_put_reg <= is_put_next;
            remain_reg <= remain_next;
            acc_reg    <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg <= sr_next;
    end

    assign done            = done_reg;
    assign taken_value     = acc_reg;
    assign overrun         = over_reg;
    assign read_bits_left  = rlim_reg - rpos_reg;
    assign write_bits_left = wlim_reg - wpos_reg;

`ifndef SYNTHESIS
    a_wpos_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        wpos_reg <= wlim_reg)
        else $error("write position past write limit");

    a_rpos_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rpos_reg <= rlim_reg)
        else $error("read position past read limit");

    a_run_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> remain_reg != '0)
        else $error("byte loop running with no bits left");

    a_overrun_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overrun) |-> taken_value == '0)
        else $error("refused field returned data");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done || state_reg == ST_RUN))
        else $error("accepted item neither running nor finished");
`endif

endmodule

@@ hw/rtl/bfpu_store.sv @@
`timescale 1ns / 1ps

module bfpu_store #(
    parameter int STORE_BYTES = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [bfpu_pkg::BFPU_ADDR_W-1:0] addr,
    input  logic [7:0]                     wdata,
    output logic [7:0]                     rdata
);
    import bfpu_pkg::*;

    localparam int IDX_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam logic [BFPU_ADDR_W:0] DEPTH = (BFPU_ADDR_W + 1)'(STORE_BYTES);

    logic [7:0]       mem_reg [STORE_BYTES];
    logic             in_range;
    logic [IDX_W-1:0] idx;

    assign in_range = {1'b0, addr} < DEPTH;
    assign idx      = addr[IDX_W-1:0];
    assign rdata    = in_range ? mem_reg[idx] : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_BYTES; i++)
            begin
                mem_reg[i] <= 8'd0;
            end
        end
        else if (we && in_range)
        begin
            mem_reg[idx] <= wdata;
        end
    end

endmodule

@@ hw/rtl/bfpu_byte_unit.sv @@
`timescale 1ns / 1ps

module bfpu_byte_unit (
    input  logic                          is_put,
    input  logic [2:0]                    bit_off,
    input  logic [bfpu_pkg::BFPU_CNT_W-1:0] remain,
    input  logic [7:0]                    wr_bits,
    input  logic [7:0]                    old_byte,
    output bfpu_pkg::byte_res_t           res
);
    import bfpu_pkg::*;

    logic [3:0] avail;
    logic [3:0] chunk;
    logic [3:0] end_off;
    logic [7:0] mask;
    logic [7:0] rd_shift;

    always_comb
    begin
        avail    = 4'd8 - {1'b0, bit_off};
        chunk    = (remain < {3'd0, avail}) ? remain[3:0] : avail;
        end_off  = {1'b0, bit_off} + chunk;
        mask     = (8'hFF >> bit_off) & ~(8'hFF >> end_off);
        rd_shift = old_byte << bit_off;

        res.chunk    = chunk;
        res.new_byte = is_put ? ((old_byte & ~mask) | ((wr_bits >> bit_off) & mask))
                              : old_byte;
        res.rd_bits  = rd_shift >> (4'd8 - chunk);
    end

endmodule

@@ test/tb_bit_field_packer_unpacker_unit.sv @@
`timescale 1ns / 1ps

module tb_bit_field_packer_unpacker_unit;
    import bfpu_pkg::*;

    localparam int ITEM_TARGET = 1750;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 25;

    typedef struct {
        logic [BFPU_VAL_W-1:0] taken;
        logic                  over;
        logic [BFPU_POS_W-1:0] rd_left;
        logic [BFPU_POS_W-1:0] wr_left;
    } field_result_t;

    class packer_scoreboard;
        logic [7:0]            msg_bytes [BFPU_STORE_BYTES];
        logic [BFPU_POS_W-1:0] wr_pos;
        logic [BFPU_POS_W-1:0] wr_lim;
        logic [BFPU_POS_W-1:0] rd_pos;
        logic [BFPU_POS_W-1:0] rd_lim;
        field_result_t         due_results [$];
        int                    errors;

        function new();
            foreach (msg_bytes[i])
                msg_bytes[i] = 8'h00;
            wr_pos = '0;
            wr_lim = '0;
            rd_pos = '0;
            rd_lim = '0;
            errors = 0;
        endfunction

        function logic read_bit(int p);
            if ((p >> 3) >= BFPU_STORE_BYTES)
                return 1'b0;
            return msg_bytes[p >> 3][7 - (p & 7)];
        endfunction

        function void write_bit(int p, logic b);
            if ((p >> 3) < BFPU_STORE_BYTES)
                msg_bytes[p >> 3][7 - (p & 7)] = b;
        endfunction

        function void note_item(op_t code, logic [BFPU_CNT_W-1:0] nbits,
                                logic [BFPU_VAL_W-1:0] value, logic [BFPU_POS_W-1:0] lim);
            field_result_t r;
            r.taken = '0;
            r.over  = 1'b0;
            case (code)
                OP_PUT:
                begin
                    if (int'(wr_pos) + int'(nbits) > int'(wr_lim))
                        r.over = 1'b1;
                    else
                        for (int k = int'(nbits); k > 0; k--)
                        begin
                            write_bit(int'(wr_pos), (k <= BFPU_VAL_W) ? value[k-1] : 1'b0);
                            wr_pos++;
                        end
                end
                OP_TAKE:
                begin
                    if (int'(rd_pos) + int'(nbits) > int'(rd_lim))
                        r.over = 1'b1;
                    else
                        for (int k = 0; k < int'(nbits); k++)
                        begin
                            r.taken = {r.taken[BFPU_VAL_W-2:0], read_bit(int'(rd_pos))};
                            rd_pos++;
                        end
                end
                OP_START_WR:
                begin
                    wr_lim = lim;
                    wr_pos = '0;
                end
                default:
                begin
                    rd_lim = lim;
                    rd_pos = '0;
                end
            endcase
            r.rd_left = rd_lim - rd_pos;
            r.wr_left = wr_lim - wr_pos;
            due_results.push_back(r);
        endfunction

        task report(string what);
            $display("ERROR %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [BFPU_VAL_W-1:0] taken, logic over,
                          logic [BFPU_POS_W-1:0] rd_left, logic [BFPU_POS_W-1:0] wr_left);
            field_result_t e;
            if (due_results.size() == 0)
            begin
                report("result with no item pending");
                return;
            end
            e = due_results.pop_front();
            if (taken !== e.taken)
                report($sformatf("taken_value %h, want %h", taken, e.taken));
            if (over !== e.over)
                report($sformatf("overrun %b, want %b", over, e.over));
            if (rd_left !== e.rd_left)
                report($sformatf("read_bits_left %0d, want %0d", rd_left, e.rd_left));
            if (wr_left !== e.wr_left)
                report($sformatf("write_bits_left %0d, want %0d", wr_left, e.wr_left));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            op;
    logic [BFPU_CNT_W-1:0] field_bits;
    logic [BFPU_VAL_W-1:0] field_value;
    logic [BFPU_POS_W-1:0] limit_bits;
    logic                  done;
    logic [BFPU_VAL_W-1:0] taken_value;
    logic                  overrun;
    logic [BFPU_POS_W-1:0] read_bits_left;
    logic [BFPU_POS_W-1:0] write_bits_left;

    packer_scoreboard sb = new();
    int               items_sent;
    int               idle_cycles;
    bit               no_gaps;

    bit_field_packer_unpacker_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .field_bits      (field_bits),
        .field_value     (field_value),
        .limit_bits      (limit_bits),
        .done            (done),
        .taken_value     (taken_value),
        .overrun         (overrun),
        .read_bits_left  (read_bits_left),
        .write_bits_left (write_bits_left)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(taken_value, overrun, read_bits_left, write_bits_left);
            if (start && !busy)
                sb.note_item(op_t'(op), field_bits, field_value, limit_bits);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_item(op_t code, logic [BFPU_CNT_W-1:0] nbits,
                             logic [BFPU_VAL_W-1:0] value, logic [BFPU_POS_W-1:0] lim);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        op          <= code;
        field_bits  <= nbits;
        field_value <= value;
        limit_bits  <= lim;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [BFPU_VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [BFPU_CNT_W-1:0] rand_bits();
        if ($urandom_range(0, 29) == 0)
            return BFPU_CNT_W'($urandom_range(65, 127));
        return BFPU_CNT_W'($urandom_range(0, 64));
    endfunction

    task automatic send_noise();
        send_item(op_t'($urandom_range(0, 3)), rand_bits(), rand_value(),
                  BFPU_POS_W'($urandom_range(0, 255)));
    endtask

    // write a message, then read it back, mostly with matching widths
    task automatic run_message();
        int lim;
        int used;
        int n;
        int widths [$];
        case ($urandom_range(0, 9))
            0: lim = 0;
            1: lim = 255;
            default: lim = $urandom_range(1, 255);
        endcase
        send_item(OP_START_WR, rand_bits(), rand_value(), BFPU_POS_W'(lim));
        used = 0;
        while (used < lim && widths.size() < 12)
        begin
            n = int'(rand_bits());
            if (used + n > lim)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(OP_PUT, BFPU_CNT_W'(n), rand_value(),
                              BFPU_POS_W'($urandom_range(0, 255)));
                n = lim - used;
                if (n > 64)
                    n = 64;
            end
            send_item(OP_PUT, BFPU_CNT_W'(n), rand_value(), BFPU_POS_W'($urandom_range(0, 255)));
            widths.push_back(n);
            used += n;
        end
        send_item(OP_START_RD, rand_bits(), rand_value(), BFPU_POS_W'(lim));
        foreach (widths[i])
        begin
            n = ($urandom_range(0, 5) == 0) ? int'(rand_bits()) : widths[i];
            send_item(OP_TAKE, BFPU_CNT_W'(n), rand_value(), BFPU_POS_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) == 0)
            send_item(OP_TAKE, rand_bits(), rand_value(), BFPU_POS_W'($urandom_range(0, 255)));
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        op          <= OP_PUT;
        field_bits  <= '0;
        field_value <= '0;
        limit_bits  <= '0;
        items_sent  = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-length and refused fields against empty limits
        send_item(OP_TAKE, 7'd0, '1, 8'hFF);
        send_item(OP_PUT, 7'd1, '1, 8'hFF);
        send_item(OP_TAKE, 7'd1, '0, 8'h00);
        // fill a full-size message, including a field wider than the value
        send_item(OP_START_WR, 7'd127, '1, 8'd255);
        send_item(OP_PUT, 7'd127, '1, 8'h00);
        send_item(OP_PUT, 7'd64, '1, 8'hFF);
        send_item(OP_PUT, 7'd64, 64'h8000_0000_0000_0001, 8'h00);
        send_item(OP_PUT, 7'd1, '1, 8'hFF);
        send_item(OP_PUT, 7'd0, '1, 8'h00);
        send_item(OP_START_RD, 7'd64, '0, 8'd255);
        send_item(OP_TAKE, 7'd127, '0, 8'hFF);
        send_item(OP_TAKE, 7'd64, '1, 8'h00);
        send_item(OP_TAKE, 7'd64, '0, 8'hFF);
        send_item(OP_TAKE, 7'd0, '1, 8'h00);
        send_item(OP_TAKE, 7'd1, '0, 8'hFF);
        // overwrite the head with a 100-bit random field and 64 zero bits, then read it back
        send_item(OP_START_WR, 7'd0, '0, 8'd200);
        send_item(OP_PUT, 7'd100, {$urandom, $urandom}, 8'h00);
        send_item(OP_PUT, 7'd64, '0, 8'hFF);
        send_item(OP_START_RD, 7'd0, '1, 8'd200);
        send_item(OP_TAKE, 7'd100, '1, 8'h00);
        send_item(OP_TAKE, 7'd64, '0, 8'hFF);
        send_item(OP_TAKE, 7'd37, '1, 8'h00);
        send_item(OP_START_WR, 7'd0, '1, 8'd0);
        send_item(OP_START_RD, 7'd0, '1, 8'd0);

        while (items_sent < ITEM_TARGET)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                run_message();
        end
        start <= 1'b0;

        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
